FILE: rtl/core/aig_and_section_decoder_unit_defines.svh
// Assertion macros for the AND-section decoder checker.
// No dependencies; included by aigsd_checker.sv.
`ifndef AIG_AND_SECTION_DECODER_UNIT_DEFINES_SVH
`define AIG_AND_SECTION_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AIGSD_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AIGSD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/aigsd_pkg.sv
// Shared types and constants for the AND-section decoder.
// No dependencies; used by the top level and the checker.
package aigsd_pkg;

	localparam int LITERAL_WIDTH_DEF = 32;
	localparam int OUT_W             = 32;
	localparam int BYTE_W            = 8;
	localparam int REG_W             = 31;
	localparam int POS_W             = 3;
	localparam int CFG_INDEX_W       = 1;

	// varint byte position saturates here; beyond byte four the varint is bad
	localparam logic [POS_W-1:0] POS_LAST = 3'd4;
	localparam logic [POS_W-1:0] POS_SAT  = 3'd5;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DELTA    = 2'd1,
		ERR_VARINT   = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_VARIABLES = 1'b0,
		REG_GATE_COUNT     = 1'b1
	} cfg_reg_t;

endpackage

FILE: rtl/core/aig_and_section_decoder_unit.sv
// AND-section varint decoder: two-stage datapath, one byte accepted per cycle unless data_stall is high.
// The result is registered from the closing byte of the second delta, which first passes the input register.
// Throughput: one byte per cycle while a stalled result does not hold the input register.
// Reset (arst_n low) or any config write clears all decoding state.
// Config resets to base_variables = 0, gate_count = 0 (section empty).
module aig_and_section_decoder_unit #(
	parameter int LITERAL_WIDTH = aigsd_pkg::LITERAL_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 data_valid,
	output logic                                 data_stall,
	input  logic [aigsd_pkg::BYTE_W-1:0]         data_byte,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [aigsd_pkg::OUT_W-1:0]          gate_literal,
	output logic [aigsd_pkg::OUT_W-1:0]          upper_literal,
	output logic [aigsd_pkg::OUT_W-1:0]          lower_literal,
	output logic                                 last_gate,
	output aigsd_pkg::err_t                      error_code,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  aigsd_pkg::cfg_reg_t                  cfg_index,
	input  logic [aigsd_pkg::REG_W-1:0]          cfg_data
);
	import aigsd_pkg::*;

	localparam int LW = LITERAL_WIDTH;
	localparam int RAW_W = REG_W + 2;
	localparam int CW = (LW > RAW_W) ? LW : RAW_W;
	localparam logic [CW-1:0] LIT_MASK = {CW{1'b1}} >> (CW - LW);

	// config
	logic [REG_W-1:0] base_q, gate_count_q;
	logic cfg_we;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// decoding state
	logic [OUT_W-1:0] acc_q;
	logic [POS_W-1:0] pos_q;
	logic             bad_q;
	logic             phase_q;
	logic [REG_W-1:0] gates_done_q;
	logic [LW-1:0]    held_upper_q;
	logic             done_q;
	err_t             held_err_q;

	logic             advance, process, active, more;
	logic [6:0]       payload;
	logic [OUT_W-1:0] contrib, acc_new, delta;
	logic             bad_new;
	logic [OUT_W-1:0] sum;
	logic [CW-1:0]    raw_c, lit_c, delta_c, held_c, upper_c, lower_c;
	logic             overflow, first_big, second_big, last;
	err_t             first_err, second_err;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign advance    = !result_valid || !result_stall;
	assign process    = valid_s1 && advance;
	assign data_stall = valid_s1 && !advance;

	assign payload = byte_s1[6:0];
	assign more    = byte_s1[7];
	assign active  = !done_q && (gates_done_q < gate_count_q);

	always_comb begin
		contrib = '0;
		case (pos_q)
			3'd0: contrib = OUT_W'(payload);
			3'd1: contrib = OUT_W'(payload) << 7;
			3'd2: contrib = OUT_W'(payload) << 14;
			3'd3: contrib = OUT_W'(payload) << 21;
			3'd4: contrib = {payload[3:0], 28'd0};
			default: contrib = '0;
		endcase
	end

	assign acc_new = acc_q | contrib;
	// fifth byte must fit in 4 bits; any sixth byte is too long
	assign bad_new = bad_q || (pos_q == POS_LAST && |payload[6:4]) || (pos_q > POS_LAST);
	assign delta   = bad_new ? '1 : acc_new;
	assign delta_c = CW'(delta);

	assign sum      = OUT_W'(gates_done_q) + OUT_W'(base_q) + OUT_W'(1);
	assign raw_c    = CW'({sum, 1'b0});
	assign lit_c    = raw_c & LIT_MASK;
	assign overflow = raw_c != lit_c;
	assign held_c   = CW'(held_upper_q);

	assign first_big  = delta_c > lit_c;
	assign second_big = delta_c > held_c;
	assign upper_c    = first_big ? '0 : lit_c - delta_c;
	assign lower_c    = second_big ? '0 : held_c - delta_c;
	assign last       = (gates_done_q + REG_W'(1)) == gate_count_q;

	always_comb begin
		if (overflow)       first_err = ERR_OVERFLOW;
		else if (bad_new)   first_err = ERR_VARINT;
		else if (first_big) first_err = ERR_DELTA;
		else                first_err = ERR_NONE;
	end

	always_comb begin
		if (held_err_q != ERR_NONE) second_err = held_err_q;
		else if (bad_new)           second_err = ERR_VARINT;
		else if (second_big)        second_err = ERR_DELTA;
		else                        second_err = ERR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			gate_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_VARIABLES: base_q <= cfg_data;
				REG_GATE_COUNT:     gate_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && !data_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			pos_q        <= '0;
			bad_q        <= 1'b0;
			phase_q      <= 1'b0;
			gates_done_q <= '0;
			held_upper_q <= '0;
			done_q       <= 1'b0;
			held_err_q   <= ERR_NONE;
		end else if (cfg_we) begin
			acc_q        <= '0;
			pos_q        <= '0;
			bad_q        <= 1'b0;
			phase_q      <= 1'b0;
			gates_done_q <= '0;
			held_upper_q <= '0;
			done_q       <= 1'b0;
			held_err_q   <= ERR_NONE;
		end else if (process && active) begin
			if (more) begin
				acc_q <= acc_new;
				bad_q <= bad_new;
				if (pos_q < POS_SAT) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else begin
				acc_q <= '0;
				pos_q <= '0;
				bad_q <= 1'b0;
				if (!phase_q) begin
					held_err_q   <= first_err;
					held_upper_q <= upper_c[LW-1:0];
					phase_q      <= 1'b1;
				end else begin
					gates_done_q <= gates_done_q + REG_W'(1);
					done_q       <= last;
					phase_q      <= 1'b0;
					held_err_q   <= ERR_NONE;
					held_upper_q <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (process && active && !more && phase_q) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && active && !more && phase_q) begin
			gate_literal  <= lit_c[OUT_W-1:0];
			upper_literal <= held_c[OUT_W-1:0];
			lower_literal <= lower_c[OUT_W-1:0];
			last_gate     <= last;
			error_code    <= second_err;
		end
	end

endmodule

FILE: rtl/core/aigsd_checker.sv
// Port-level checker for the AND-section decoder, bound to the top level.
// Depends on aigsd_pkg and aig_and_section_decoder_unit_defines.svh.
`include "aig_and_section_decoder_unit_defines.svh"

module aigsd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic [aigsd_pkg::OUT_W-1:0]  gate_literal,
	input logic [aigsd_pkg::OUT_W-1:0]  upper_literal,
	input logic [aigsd_pkg::OUT_W-1:0]  lower_literal,
	input logic                         last_gate,
	input aigsd_pkg::err_t              error_code
);
	import aigsd_pkg::*;

	// stalled result request holds
	`AIGSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(gate_literal) && $stable(upper_literal) && $stable(lower_literal) && $stable(last_gate) && $stable(error_code))

	// gate literals are always even, wrapped or not
	`AIGSD_ASSERT_SAME(a_gate_even, result_valid, !gate_literal[0])

	// an oversized delta saturates the final literal to zero
	`AIGSD_ASSERT_SAME(a_delta_sat, result_valid && error_code == ERR_DELTA, lower_literal == '0)

	// nothing follows the final gate
	`AIGSD_ASSERT_NEXT(a_last_ends, result_valid && !result_stall && last_gate, !result_valid)

endmodule

bind aig_and_section_decoder_unit aigsd_checker u_aigsd_checker (.*);

FILE: dv/aig_and_section_decoder_unit_tb.sv
// Testbench for aig_and_section_decoder_unit: feeds binary AND-section bytes and
// register writes, predicts every decoded gate and checks the results in order.
// Depends on aigsd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module aig_and_section_decoder_unit_tb;
	import aigsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES = 780;
	localparam logic [63:0] LIT_MASK = {64{1'b1}} >> (64 - LITERAL_WIDTH_DEF);

	typedef struct packed {
		logic [OUT_W-1:0] gate_lit;
		logic [OUT_W-1:0] upper_lit;
		logic [OUT_W-1:0] lower_lit;
		logic             last;
		err_t             err;
	} gate_result_t;

	logic              clk;
	logic              arst_n;
	logic              data_valid;
	logic              data_stall;
	logic [BYTE_W-1:0] data_byte;
	logic              result_valid;
	logic              result_stall;
	logic [OUT_W-1:0]  gate_literal;
	logic [OUT_W-1:0]  upper_literal;
	logic [OUT_W-1:0]  lower_literal;
	logic              last_gate;
	err_t              error_code;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_reg_t          cfg_index;
	logic [REG_W-1:0]  cfg_data;

	// shadow of the decoder
	logic [REG_W-1:0] mdl_base;
	logic [REG_W-1:0] mdl_count;
	logic [31:0]      acc;
	logic [POS_W-1:0] vpos;
	logic             in_second;
	logic [REG_W-1:0] gates_seen;
	logic [63:0]      upper_hold;
	logic             section_closed;
	logic             varint_broken;
	err_t             gate_err;

	gate_result_t      gates_due[$];
	logic [BYTE_W-1:0] section_bytes[$];

	int cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int bytes_decoded = 0;
	int reg_writes = 0;
	int results_seen = 0;
	int err_hits[4] = '{0, 0, 0, 0};
	int gap_max;
	int stall_max;

	aig_and_section_decoder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.gate_literal (gate_literal),
		.upper_literal(upper_literal),
		.lower_literal(lower_literal),
		.last_gate    (last_gate),
		.error_code   (error_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d gates still due", cycles, gates_due.size());
			$display("aig_and_section_decoder_unit_tb: errors");
			$finish;
		end
	end

	function automatic int draw_wait(input int max_wait);
		return (max_wait == 0) ? 0 : int'($urandom_range(max_wait));
	endfunction

	task automatic restart_section();
		acc = '0;
		vpos = '0;
		in_second = 1'b0;
		gates_seen = '0;
		upper_hold = '0;
		section_closed = 1'b0;
		varint_broken = 1'b0;
		gate_err = ERR_NONE;
	endtask

	// advances the shadow decoder by one accepted byte
	task automatic track_section_byte(input logic [BYTE_W-1:0] b);
		logic [63:0]  delta;
		logic [63:0]  raw;
		logic [63:0]  lit;
		logic [63:0]  lower;
		gate_result_t r;
		if (section_closed || gates_seen >= mdl_count)
			return;
		bytes_decoded++;
		if (vpos < POS_LAST)
			acc = acc | (32'(b[6:0]) << (7 * vpos));
		else if (vpos == POS_LAST) begin
			acc = acc | (32'(b[6:0]) << 28);
			if (b[6:4] != 3'b000)
				varint_broken = 1'b1;
		end else
			varint_broken = 1'b1;
		if (b[7]) begin
			if (vpos < POS_SAT)
				vpos = vpos + 1'b1;
			return;
		end
		delta = varint_broken ? 64'hFFFF_FFFF : 64'(acc);
		raw = (64'(gates_seen) + 64'd1 + 64'(mdl_base)) << 1;
		lit = raw & LIT_MASK;
		acc = '0;
		vpos = '0;
		if (!in_second) begin
			gate_err = ERR_NONE;
			if (raw != lit)
				gate_err = ERR_OVERFLOW;
			else if (varint_broken)
				gate_err = ERR_VARINT;
			else if (delta > lit)
				gate_err = ERR_DELTA;
			upper_hold = (delta > lit) ? 64'd0 : lit - delta;
			in_second = 1'b1;
			varint_broken = 1'b0;
			return;
		end
		if (gate_err == ERR_NONE) begin
			if (varint_broken)
				gate_err = ERR_VARINT;
			else if (delta > upper_hold)
				gate_err = ERR_DELTA;
		end
		lower = (delta > upper_hold) ? 64'd0 : upper_hold - delta;
		gates_seen = gates_seen + 1'b1;
		r.gate_lit = lit[OUT_W-1:0];
		r.upper_lit = upper_hold[OUT_W-1:0];
		r.lower_lit = lower[OUT_W-1:0];
		r.last = (gates_seen == mdl_count);
		r.err = gate_err;
		gates_due.push_back(r);
		section_closed = r.last;
		in_second = 1'b0;
		varint_broken = 1'b0;
		gate_err = ERR_NONE;
		upper_hold = '0;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH %s: got %h want %h (gate %0d)", what, got, want, results_seen);
	endtask

	always @(posedge clk) begin
		gate_result_t due;
		if (arst_n && result_valid && !result_stall) begin
			if (gates_due.size() == 0)
				report("unexpected result", gate_literal, '0);
			else begin
				due = gates_due.pop_front();
				if (gate_literal !== due.gate_lit)
					report("gate_literal", gate_literal, due.gate_lit);
				if (upper_literal !== due.upper_lit)
					report("upper_literal", upper_literal, due.upper_lit);
				if (lower_literal !== due.lower_lit)
					report("lower_literal", lower_literal, due.lower_lit);
				if (last_gate !== due.last)
					report("last_gate", 32'(last_gate), 32'(due.last));
				if (error_code !== due.err)
					report("error_code", 32'(error_code), 32'(due.err));
				err_hits[due.err]++;
				results_seen++;
			end
		end
	end

	// result side: random stall before each result
	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = draw_wait(stall_max);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_wait(gap_max);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (data_stall);
		track_section_byte(b);
		bytes_sent++;
	endtask

	task automatic send_planned();
		while (section_bytes.size() > 0)
			send_byte(section_bytes.pop_front());
	endtask

	task automatic pause_until_drained();
		data_valid <= 1'b0;
		do @(posedge clk); while (gates_due.size() != 0);
	endtask

	task automatic wait_results_done();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_section(input bit set_base, input logic [REG_W-1:0] base,
			input bit set_count, input logic [REG_W-1:0] count);
		wait_results_done();
		cfg_valid <= 1'b1;
		if (set_base) begin
			cfg_index <= REG_BASE_VARIABLES;
			cfg_data <= base;
			do @(posedge clk); while (!cfg_ready);
			mdl_base = base;
			restart_section();
			reg_writes++;
		end
		if (set_count) begin
			cfg_index <= REG_GATE_COUNT;
			cfg_data <= count;
			do @(posedge clk); while (!cfg_ready);
			mdl_count = count;
			restart_section();
			reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// queues one delta taken from literal 'from'; returns the literal left over
	function automatic logic [63:0] plan_delta(input logic [63:0] from);
		logic [63:0] d;
		logic [31:0] rest;
		int pick;
		int len;
		int pad;
		int k;
		pick = $urandom_range(99);
		if (pick < 7) begin
			// runs past five bytes
			len = $urandom_range(6, 9);
			for (k = 0; k < len - 1; k++)
				section_bytes.push_back({1'b1, 7'($urandom)});
			section_bytes.push_back({1'b0, 7'($urandom)});
			return 64'd0;
		end
		if (pick < 12) begin
			// fifth byte carries bits above 32
			for (k = 0; k < 4; k++)
				section_bytes.push_back({1'b1, 7'($urandom)});
			section_bytes.push_back({1'b0, 3'($urandom_range(1, 7)), 4'($urandom)});
			return 64'd0;
		end
		if (pick < 50)
			d = 64'($urandom_range((from > 200) ? 200 : 32'(from)));
		else if (pick < 78)
			d = 64'($urandom) % (from + 64'd1);
		else if (pick < 85)
			d = from;
		else if (pick < 94)
			d = from + 64'd1 + 64'($urandom_range(300));
		else
			d = 64'($urandom);
		if (d > 64'hFFFF_FFFF)
			d = 64'hFFFF_FFFF;
		rest = d[31:0];
		len = 1;
		for (k = 1; k < 5; k++)
			if ((rest >> (7 * k)) != 0)
				len = k + 1;
		// redundant high zero bytes, still within five
		pad = ($urandom_range(9) == 0 && len < 5) ? $urandom_range(1, 5 - len) : 0;
		for (k = 0; k < len + pad; k++)
			section_bytes.push_back({k < len + pad - 1, 7'(rest >> (7 * k))});
		return (d > from) ? 64'd0 : from - d;
	endfunction

	task automatic plan_gate(input int idx);
		logic [63:0] upper;
		upper = plan_delta(((64'(idx) + 64'd1 + 64'(mdl_base)) << 1) & LIT_MASK);
		void'(plan_delta(upper));
	endtask

	// reset state has gate_count zero: every byte is dropped
	task automatic test_empty_section();
		section_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00};
		send_planned();
	endtask

	task automatic test_delta_cases();
		program_section(1'b1, '0, 1'b1, 31'd6);
		section_bytes = '{
			8'h00, 8'h00,                             // zero deltas
			8'h05, 8'h00,                             // first delta above literal
			8'h01, 8'hFF, 8'h7F,                      // second delta above upper
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, // all-ones five-byte delta
			8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h02, // fifth byte too wide
			8'h02, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01, // sixth byte, last gate
			8'h00, 8'hFF                              // past the last gate
		};
		send_planned();
	endtask

	// second gate literal crosses 32 bits, overflow wins over the bad delta
	task automatic test_literal_overflow();
		program_section(1'b1, 31'h7FFF_FFFE, 1'b1, 31'd2);
		section_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h55};
		send_planned();
	endtask

	task automatic test_drain_pause();
		int k;
		program_section(1'b1, 31'($urandom_range(5000)), 1'b1, 31'd8);
		for (k = 0; k < 4; k++)
			plan_gate(k);
		send_planned();
		pause_until_drained();
		for (k = 4; k < 8; k++)
			plan_gate(k);
		send_planned();
	endtask

	task automatic test_random_sections();
		int start;
		int gates;
		int k;
		int pick;
		logic [REG_W-1:0] base;
		logic [REG_W-1:0] count;
		start = bytes_decoded;
		while (bytes_decoded - start < RANDOM_BYTES) begin
			pick = $urandom_range(9);
			if (pick < 5)
				base = 31'($urandom_range(1000));
			else if (pick == 5)
				base = '0;
			else if (pick == 6)
				base = 31'h7FFF_FFFF;
			else if (pick == 7)
				base = 31'h7FFF_FFFF - 31'($urandom_range(12));
			else
				base = 31'($urandom);
			pick = $urandom_range(9);
			count = (pick == 0) ? '0 : (pick == 1) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 30));
			gap_max = ($urandom_range(3) == 0) ? 0 : 17;
			stall_max = ($urandom_range(3) == 0) ? 0 : 17;
			pick = $urandom_range(9);
			program_section(pick != 9, base, pick != 8, count);
			gates = (mdl_count > 40) ? int'($urandom_range(1, 40)) : int'(mdl_count);
			if ($urandom_range(6) == 0 || gates == 0)
				gates = gates + $urandom_range(1, 3);
			for (k = 0; k < gates; k++) begin
				if ($urandom_range(24) == 0) begin
					repeat ($urandom_range(1, 6))
						section_bytes.push_back(8'($urandom));
				end else
					plan_gate(k);
			end
			// sometimes the section is cut short mid-gate
			if ($urandom_range(6) == 0 && section_bytes.size() > 1)
				repeat ($urandom_range(1, 3))
					void'(section_bytes.pop_back());
			send_planned();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_VARIABLES;
		cfg_data = '0;
		gap_max = 17;
		stall_max = 17;
		mdl_base = '0;
		mdl_count = '0;
		restart_section();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_section();
		test_delta_cases();
		test_literal_overflow();
		test_drain_pause();
		test_random_sections();
		wait_results_done();

		$display("sent %0d bytes (%0d decoded), %0d register writes, %0d gates checked",
			bytes_sent, bytes_decoded, reg_writes, results_seen);
		$display("gate status: ok %0d, delta %0d, varint %0d, overflow %0d",
			err_hits[ERR_NONE], err_hits[ERR_DELTA], err_hits[ERR_VARINT],
			err_hits[ERR_OVERFLOW]);
		if (mismatches == 0)
			$display("aig_and_section_decoder_unit_tb: clean");
		else
			$display("aig_and_section_decoder_unit_tb: errors");
		$finish;
	end

endmodule
